// ----- design/dllr_pkg.sv -----
// ----------------------------------------------------------------------------
// dllr_pkg: shared constants for the Dunning log-likelihood scorer
// Fixed-point formats, term order of the contingency lanes, pipeline depths.
// ----------------------------------------------------------------------------
package dllr_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int INDEX_BITS_DEF = 20;
    localparam int FRAC_BITS_DEF  = 12;

    // ln(x) carries LN_FRAC fraction bits; log2 integer part is LG_INT_BITS wide
    localparam int LN_FRAC     = 28;
    localparam int LG_INT_BITS = 5;
    localparam int LG_BITS     = LG_INT_BITS + LN_FRAC;
    localparam int MANT_BITS   = 32;
    localparam int LN2_BITS    = 30;
    localparam logic [LN2_BITS-1:0] LN2_Q30 = 30'd744261118;
    localparam int LN_BITS     = 64 - LN2_BITS;

    localparam int SUM_BITS = 64;
    localparam int OUT_BITS = 63;
    localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

    // x*ln(x) lanes, one per entropy term
    localparam int NUM_TERMS = 9;
    localparam int T_TOTAL   = 0;
    localparam int T_K11     = 1;
    localparam int T_K12     = 2;
    localparam int T_K21     = 3;
    localparam int T_K22     = 4;
    localparam int T_ROW1    = 5;
    localparam int T_ROW2    = 6;
    localparam int T_COL1    = 7;
    localparam int T_COL2    = 8;

    // register stages per unit
    localparam int CELL_STAGES  = 1;
    localparam int LN_STAGES    = LN_FRAC + 3;
    localparam int SCORE_STAGES = 4;
    localparam int LATENCY      = CELL_STAGES + LN_STAGES + SCORE_STAGES;

endpackage

// ----- design/dllr_cells.sv -----
// ----------------------------------------------------------------------------
// dllr_cells: contingency table builder
// Forms the four cells, clamps negative cells to zero and registers the
// nine entropy arguments together with the clamp flag.
// ----------------------------------------------------------------------------
module dllr_cells #(
    parameter int COUNT_BITS = dllr_pkg::COUNT_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            en,
    input  logic [COUNT_BITS-1:0]                           pair_count,
    input  logic [COUNT_BITS-1:0]                           total_row,
    input  logic [COUNT_BITS-1:0]                           total_col,
    input  logic [COUNT_BITS-1:0]                           grand_total,
    output logic [dllr_pkg::NUM_TERMS-1:0][COUNT_BITS+2:0]  x_reg,
    output logic                                            clamp_reg
);
    import dllr_pkg::*;

    localparam int XW = COUNT_BITS + 3;

    logic signed [COUNT_BITS:0]   d12;
    logic signed [COUNT_BITS:0]   d21;
    logic signed [COUNT_BITS+2:0] d22;
    logic [XW-1:0] k11, k12, k21, k22;
    logic [NUM_TERMS-1:0][XW-1:0] x_next;
    logic clamp_next;

    always_comb
    begin
        d12 = $signed({1'b0, total_col}) - $signed({1'b0, pair_count});
        d21 = $signed({1'b0, total_row}) - $signed({1'b0, pair_count});
        d22 = $signed({3'b000, grand_total}) - $signed({3'b000, total_row})
            - $signed({3'b000, total_col}) + $signed({3'b000, pair_count});

        k11 = XW'(pair_count);
        k12 = d12[COUNT_BITS]   ? '0 : XW'(d12[COUNT_BITS-1:0]);
        k21 = d21[COUNT_BITS]   ? '0 : XW'(d21[COUNT_BITS-1:0]);
        k22 = d22[COUNT_BITS+2] ? '0 : XW'(d22[COUNT_BITS:0]);
        clamp_next = d12[COUNT_BITS] | d21[COUNT_BITS] | d22[COUNT_BITS+2];

        x_next          = '0;
        x_next[T_TOTAL] = k11 + k12 + k21 + k22;
        x_next[T_K11]   = k11;
        x_next[T_K12]   = k12;
        x_next[T_K21]   = k21;
        x_next[T_K22]   = k22;
        x_next[T_ROW1]  = k11 + k12;
        x_next[T_ROW2]  = k21 + k22;
        x_next[T_COL1]  = k11 + k21;
        x_next[T_COL2]  = k12 + k22;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x_next;
            clamp_reg <= clamp_next;
        end
    end

endmodule

// ----- design/dllr_ln.sv -----
// ----------------------------------------------------------------------------
// dllr_ln: one x*ln(x) lane
// Normalize, one squaring stage per log2 fraction bit, scale by ln 2,
// multiply by x. Zero input yields zero.
// ----------------------------------------------------------------------------
module dllr_ln #(
    parameter int XW = dllr_pkg::COUNT_BITS_DEF + 3
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [XW-1:0]                 x,
    output logic [dllr_pkg::SUM_BITS-1:0] xlog_reg
);
    import dllr_pkg::*;

    logic [LG_INT_BITS-1:0] n_norm;
    logic [LG_INT_BITS-1:0] sh_norm;

    logic [MANT_BITS-1:0]   m_reg    [LN_FRAC+1];
    logic [LN_FRAC-1:0]     frac_reg [LN_FRAC+1];
    logic [LG_INT_BITS-1:0] n_reg    [LN_FRAC+1];
    logic [XW-1:0]          x_reg    [LN_FRAC+1];

    logic [LG_BITS-1:0] lg;
    logic [63:0]        ln_prod;
    logic [LN_BITS-1:0] ln_reg;
    logic [XW-1:0]      xl_reg;

    // leading one position
    always_comb
    begin
        n_norm = '0;
        for (int i = 0; i < XW; i++)
        begin
            if (x[i])
                n_norm = LG_INT_BITS'(i);
        end
        sh_norm = LG_INT_BITS'(MANT_BITS - 1) - n_norm;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]    <= MANT_BITS'(x) << sh_norm;
            frac_reg[0] <= '0;
            n_reg[0]    <= n_norm;
            x_reg[0]    <= x;
        end
    end

    for (genvar k = 0; k < LN_FRAC; k++)
    begin : g_sq
        logic [2*MANT_BITS-1:0] sq;
        logic [MANT_BITS:0]     t;

        always_comb
        begin
            sq = (2*MANT_BITS)'(m_reg[k]) * (2*MANT_BITS)'(m_reg[k]);
            t  = sq[2*MANT_BITS-1:MANT_BITS-1];
        end

        // renormalize when the square reaches two
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[k+1]    <= t[MANT_BITS] ? t[MANT_BITS:1] : t[MANT_BITS-1:0];
                frac_reg[k+1] <= {frac_reg[k][LN_FRAC-2:0], t[MANT_BITS]};
                n_reg[k+1]    <= n_reg[k];
                x_reg[k+1]    <= x_reg[k];
            end
        end
    end

    always_comb
    begin
        lg      = {n_reg[LN_FRAC], frac_reg[LN_FRAC]};
        ln_prod = 64'(lg) * 64'(LN2_Q30) + (64'd1 << (LN2_BITS - 1));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ln_reg   <= ln_prod[63:LN2_BITS];
            xl_reg   <= x_reg[LN_FRAC];
            xlog_reg <= SUM_BITS'(xl_reg) * SUM_BITS'(ln_reg);
        end
    end

endmodule

// ----- design/dllr_score.sv -----
// ----------------------------------------------------------------------------
// dllr_score: ratio, scaling and saturation
// Sums the entropy terms, clamps the ratio at zero, scales by the grand
// total in two halves and saturates into the output register.
// ----------------------------------------------------------------------------
module dllr_score #(
    parameter int COUNT_BITS = dllr_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = dllr_pkg::FRAC_BITS_DEF
) (
    input  logic                                                 clk,
    input  logic                                                 en,
    input  logic [dllr_pkg::NUM_TERMS-1:0][dllr_pkg::SUM_BITS-1:0] xlog,
    input  logic [COUNT_BITS-1:0]                                grand_total,
    output logic [dllr_pkg::OUT_BITS-1:0]                        llr_reg_out,
    output logic                                                 sat_reg
);
    import dllr_pkg::*;

    localparam int SH  = LN_FRAC - FRAC_BITS;
    localparam int UP  = 32 - SH;
    localparam int PW  = 32 + COUNT_BITS;
    localparam logic [63:0] THR = 64'h7FFF_FFFF_FFFF_FFFF >> UP;

    logic [SUM_BITS-1:0] pos_reg, neg_reg, llr_reg;
    logic [PW-1:0]       lo_reg, hi_reg;
    logic [63:0]         res;
    logic                sat_next;
    logic [OUT_BITS-1:0] out_next;

    always_comb
    begin
        res      = (64'(hi_reg) << UP) + (64'(lo_reg) >> SH);
        sat_next = (64'(hi_reg) >= THR) || (res >= 64'(OUT_MAX));
        out_next = sat_next ? OUT_MAX : res[OUT_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg <= xlog[T_TOTAL] + xlog[T_K11] + xlog[T_K12]
                     + xlog[T_K21] + xlog[T_K22];
            neg_reg <= xlog[T_ROW1] + xlog[T_ROW2] + xlog[T_COL1] + xlog[T_COL2];
            // drop a negative ratio to zero
            llr_reg <= (pos_reg > neg_reg) ? ((pos_reg - neg_reg) << 1) : '0;
            lo_reg  <= PW'(llr_reg[31:0]) * PW'(grand_total);
            hi_reg  <= PW'(llr_reg[63:32]) * PW'(grand_total);
            llr_reg_out <= out_next;
            sat_reg     <= sat_next;
        end
    end

endmodule

// ----- design/dunning_llr_score_top.sv -----
// ----------------------------------------------------------------------------
// dunning_llr_score_top: Dunning log-likelihood ratio scorer
// One co-occurrence entry in, one scaled ratio with its indices out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries pair_count, total_row, total_col
//   and the two indices; an item is taken at a clock edge with in_valid high
//   and in_stall low. Results leave on out_valid/out_stall the same way.
//   grand_total is written through cfg_wr_en/cfg_wr_data; the user must write it
//   only while no item is in flight, as the block does not enforce it; it resets to zero.
//   The pipeline has 36 register stages: one cell stage, 31 stages per
//   x*ln(x) lane (normalize, 28 squarings, ln 2 scale, multiply) and four
//   scoring stages ending in the output register.
//   Throughput is one item per cycle when not stalled; the nine lanes run side
//   by side and each lane stage holds at most one 32x32 squaring or one multiply.
//   The whole pipeline advances together. While out_valid is high and
//   out_stall is high, every stage holds and in_stall is raised; no item is
//   lost or repeated. Reset clears all valid bits and the configuration.
// ----------------------------------------------------------------------------
module dunning_llr_score_top #(
    parameter int COUNT_BITS = dllr_pkg::COUNT_BITS_DEF,
    parameter int INDEX_BITS = dllr_pkg::INDEX_BITS_DEF,
    parameter int FRAC_BITS  = dllr_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [COUNT_BITS-1:0]         cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [COUNT_BITS-1:0]         pair_count,
    input  logic [COUNT_BITS-1:0]         total_row,
    input  logic [COUNT_BITS-1:0]         total_col,
    input  logic [INDEX_BITS-1:0]         row_index,
    input  logic [INDEX_BITS-1:0]         col_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dllr_pkg::OUT_BITS-1:0] llr_scaled,
    output logic [INDEX_BITS-1:0]         row_index_res,
    output logic [INDEX_BITS-1:0]         col_index_res,
    output logic                          cell_clamped,
    output logic                          saturated
);
    import dllr_pkg::*;

    localparam int XW = COUNT_BITS + 3;

    logic                   adv;
    logic [COUNT_BITS-1:0]  gt_reg;
    logic                   vld_reg   [LATENCY];
    logic [INDEX_BITS-1:0]  row_reg   [LATENCY];
    logic [INDEX_BITS-1:0]  col_reg   [LATENCY];
    logic                   clamp_reg [LATENCY];
    logic                   cell_clamp;
    logic [NUM_TERMS-1:0][XW-1:0]       x_cells;
    logic [NUM_TERMS-1:0][SUM_BITS-1:0] xlog;

    assign adv      = !(vld_reg[LATENCY-1] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gt_reg <= '0;
        else if (cfg_wr_en)
            gt_reg <= cfg_wr_data;
    end

    // valid bits and side fields travel alongside the arithmetic
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LATENCY; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LATENCY; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            row_reg[0]   <= row_index;
            col_reg[0]   <= col_index;
            clamp_reg[0] <= 1'b0;
            for (int i = 1; i < LATENCY; i++)
            begin
                row_reg[i]   <= row_reg[i-1];
                col_reg[i]   <= col_reg[i-1];
                clamp_reg[i] <= (i == CELL_STAGES) ? cell_clamp : clamp_reg[i-1];
            end
        end
    end

    dllr_cells #(
        .COUNT_BITS (COUNT_BITS)
    ) u_cells (
        .clk         (clk),
        .en          (adv),
        .pair_count  (pair_count),
        .total_row   (total_row),
        .total_col   (total_col),
        .grand_total (gt_reg),
        .x_reg       (x_cells),
        .clamp_reg   (cell_clamp)
    );

    for (genvar t = 0; t < NUM_TERMS; t++)
    begin : g_lane
        dllr_ln #(
            .XW (XW)
        ) u_ln (
            .clk      (clk),
            .en       (adv),
            .x        (x_cells[t]),
            .xlog_reg (xlog[t])
        );
    end

    dllr_score #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_score (
        .clk         (clk),
        .en          (adv),
        .xlog        (xlog),
        .grand_total (gt_reg),
        .llr_reg_out (llr_scaled),
        .sat_reg     (saturated)
    );

    assign out_valid     = vld_reg[LATENCY-1];
    assign row_index_res = row_reg[LATENCY-1];
    assign col_index_res = col_reg[LATENCY-1];
    assign cell_clamped  = clamp_reg[LATENCY-1];

endmodule

// ----- design/dllr_check.sv -----
// ----------------------------------------------------------------------------
// dllr_check: port-level checks for the Dunning scorer
// Watches handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module dllr_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [dllr_pkg::OUT_BITS-1:0] llr_scaled,
    input logic                          saturated
);
    import dllr_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(llr_scaled))
        else $error("stalled result changed");

    // back-pressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> llr_scaled == OUT_MAX)
        else $error("saturated flag without maximum value");

    a_nosat_below: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !saturated |-> llr_scaled != OUT_MAX)
        else $error("maximum value without saturated flag");

endmodule

bind dunning_llr_score_top dllr_check u_dllr_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .llr_scaled (llr_scaled),
    .saturated  (saturated)
);

// ----- tb/dunning_llr_score_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dunning_llr_score_checker: score predictor and result comparator
// Watches both channels of the scorer, predicts each score from the accepted
// entry and the current grand total, and compares results in order.
// ----------------------------------------------------------------------------
module dunning_llr_score_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [23:0] pair_count,
    input  logic [23:0] total_row,
    input  logic [23:0] total_col,
    input  logic [19:0] row_index,
    input  logic [19:0] col_index,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [62:0] llr_scaled,
    input  logic [19:0] row_index_res,
    input  logic [19:0] col_index_res,
    input  logic        cell_clamped,
    input  logic        saturated,
    output int          fail_count,
    output int          pending
);

    localparam int SHIFT = dllr_pkg::LN_FRAC - dllr_pkg::FRAC_BITS_DEF;

    typedef struct packed {
        logic [62:0] score;
        logic [19:0] row_idx;
        logic [19:0] col_idx;
        logic        clamped;
        logic        sat;
    } score_t;

    score_t      expected_scores[$];
    logic [23:0] grand_total_q;

    // ln(x) with 28 fraction bits, x >= 1
    function automatic logic [63:0] ln_q28(input logic [63:0] x);
        int          msb;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] lg;
        msb = 0;
        frac = 0;
        for (int i = 0; i < 31; i++)
            if (x[i])
                msb = i;
        m = (x << (31 - msb)) & 64'hFFFF_FFFF;
        for (int i = 0; i < dllr_pkg::LN_FRAC; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        lg = (64'(msb) << dllr_pkg::LN_FRAC) | frac;
        return (lg * 64'd744261118 + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [63:0] xlnx(input logic [63:0] x);
        if (x == 0)
            return 0;
        return x * ln_q28(x);
    endfunction

    function automatic score_t predict_score(input logic [23:0] pc, input logic [23:0] tr,
                                             input logic [23:0] tc, input logic [19:0] ri,
                                             input logic [19:0] ci, input logic [23:0] gt);
        score_t            r;
        longint            k11, k12, k21, k22;
        logic [63:0]       pos, neg, llr, lo, hi, res;
        logic [62:0]       omax;
        r.clamped = 0;
        r.sat = 0;
        omax = '1;
        k11 = pc;
        k12 = longint'(tc) - pc;
        k21 = longint'(tr) - pc;
        k22 = longint'(gt) - (longint'(tr) + tc) + pc;
        if (k12 < 0) begin k12 = 0; r.clamped = 1; end
        if (k21 < 0) begin k21 = 0; r.clamped = 1; end
        if (k22 < 0) begin k22 = 0; r.clamped = 1; end
        pos = xlnx(k11 + k12 + k21 + k22) + xlnx(k11) + xlnx(k12) + xlnx(k21) + xlnx(k22);
        neg = xlnx(k11 + k12) + xlnx(k21 + k22) + xlnx(k11 + k21) + xlnx(k12 + k22);
        llr = (pos > neg) ? 2 * (pos - neg) : 0;
        lo = (llr & 64'hFFFF_FFFF) * gt;
        hi = (llr >> 32) * gt;
        if (hi >= (64'(omax) >> (32 - SHIFT)))
        begin
            res = 64'(omax);
            r.sat = 1;
        end
        else
        begin
            res = (hi << (32 - SHIFT)) + (lo >> SHIFT);
            if (res >= 64'(omax))
            begin
                res = 64'(omax);
                r.sat = 1;
            end
        end
        r.score = res[62:0];
        r.row_idx = ri;
        r.col_idx = ci;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        score_t want;
        if (!rst_n)
        begin
            grand_total_q <= '0;
            expected_scores.delete();
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_scores = {expected_scores,
                                   predict_score(pair_count, total_row, total_col,
                                                 row_index, col_index, grand_total_q)};
            if (cfg_wr_en)
                grand_total_q <= cfg_wr_data;
            if (out_valid && !out_stall)
            begin
                if (expected_scores.size() == 0)
                begin
                    report_mismatch("unexpected out_valid", 1, 0);
                end
                else
                begin
                    want = expected_scores.pop_front();
                    if (llr_scaled !== want.score)
                        report_mismatch("llr_scaled", llr_scaled, want.score);
                    if (row_index_res !== want.row_idx)
                        report_mismatch("row_index_res", row_index_res, want.row_idx);
                    if (col_index_res !== want.col_idx)
                        report_mismatch("col_index_res", col_index_res, want.col_idx);
                    if (cell_clamped !== want.clamped)
                        report_mismatch("cell_clamped", cell_clamped, want.clamped);
                    if (saturated !== want.sat)
                        report_mismatch("saturated", saturated, want.sat);
                end
            end
            pending <= expected_scores.size();
        end
    end

endmodule

// ----- tb/dunning_llr_score_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dunning_llr_score_top_tb: stimulus and verdict for the LLR scorer
// Drives directed and random co-occurrence entries under several grand
// totals with random idling on both sides; the checker scores every result.
// ----------------------------------------------------------------------------
module dunning_llr_score_top_tb;

    localparam int  CYCLE_LIMIT = 200000;
    localparam int  DRAIN_CYCLES = 60;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [23:0] cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [23:0] pair_count;
    logic [23:0] total_row;
    logic [23:0] total_col;
    logic [19:0] row_index;
    logic [19:0] col_index;
    logic        out_valid;
    logic        out_stall;
    logic [62:0] llr_scaled;
    logic [19:0] row_index_res;
    logic [19:0] col_index_res;
    logic        cell_clamped;
    logic        saturated;
    int          fail_count;
    int          pending;
    int          cycle_count;
    bit          calm;
    bit          hold_off;

    dunning_llr_score_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .pair_count(pair_count), .total_row(total_row), .total_col(total_col),
        .row_index(row_index), .col_index(col_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .llr_scaled(llr_scaled), .row_index_res(row_index_res),
        .col_index_res(col_index_res), .cell_clamped(cell_clamped),
        .saturated(saturated)
    );

    dunning_llr_score_checker u_checker (.*);

    initial clk = 0;
    always #6 clk = ~clk;

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver: random stalls, long hold-off on request
    initial
    begin
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1;
                repeat (120) @(negedge clk);
                hold_off = 0;
            end
            out_stall <= !calm && ($urandom_range(99) < 26);
        end
    end

    task automatic send_entry(input logic [23:0] pc, input logic [23:0] tr,
                              input logic [23:0] tc);
        while (!calm && $urandom_range(99) < 26)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        pair_count <= pc;
        total_row <= tr;
        total_col <= tc;
        row_index <= $urandom;
        col_index <= $urandom;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic settle_and_write(input logic [23:0] gt);
        in_valid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wr_en <= 1;
        cfg_wr_data <= gt;
        @(negedge clk);
        cfg_wr_en <= 0;
    endtask

    // mostly consistent entries: pair <= both totals, totals fit the grand total
    task automatic random_entry(input logic [23:0] gt);
        logic [23:0] pc, tr, tc;
        int          mode;
        mode = $urandom_range(9);
        if (mode < 7)
        begin
            tr = (gt == 0) ? 0 : $urandom_range(gt / 2);
            tc = (gt == 0) ? 0 : $urandom_range(gt / 2);
            pc = $urandom_range((tr < tc) ? tr : tc);
        end
        else if (mode < 9)
        begin
            tr = $urandom_range(255);
            tc = $urandom_range(255);
            pc = $urandom_range(255);
        end
        else
        begin
            pc = $urandom;
            tr = $urandom;
            tc = $urandom;
        end
        send_entry(pc, tr, tc);
    endtask

    initial
    begin
        logic [23:0] settings[6];
        logic [23:0] gt;
        settings = '{24'd0, 24'd1000, 24'd65536, 24'd5000000, 24'hFFFFFF, 24'd300};
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        in_valid = 0;
        pair_count = 0;
        total_row = 0;
        total_col = 0;
        row_index = 0;
        col_index = 0;
        calm = 0;
        hold_off = 0;
        repeat (8) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: zero grand total first, then full scale
        send_entry(0, 0, 0);
        send_entry(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        settle_and_write(24'hFFFFFF);
        send_entry(0, 0, 0);
        send_entry(1, 1, 1);
        send_entry(10, 5, 3);
        send_entry(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_entry(1, 24'h7FFFFF, 24'h7FFFFF);
        send_entry(24'h400000, 24'h800000, 24'h7FFFFF);
        send_entry(100, 200, 300);
        send_entry(0, 24'h800000, 24'h7FFFFF);
        send_entry(24'h555555, 24'hAAAAAA, 24'h555555);
        settle_and_write(24'd1000);
        send_entry(5, 10, 20);
        send_entry(0, 1000, 0);
        send_entry(500, 500, 500);
        send_entry(1, 2, 3);

        foreach (settings[s])
        begin
            gt = settings[s];
            settle_and_write(gt);
            calm = (s == 3);
            for (int i = 0; i < 225; i++)
            begin
                if (s == 2 && i == 20)
                    hold_off = 1;
                random_entry(gt);
            end
        end
        calm = 0;

        in_valid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
